### rtl/lhdcp_pkg.sv
// Package for the list header day/check parser.
// Holds the scan phase type and the character codes; no dependencies.
`timescale 1ns / 1ps

package lhdcp_pkg;

	// Scan phases of the header line.
	typedef enum logic [2:0] {
		PH_DASH   = 3'd0,
		PH_FDIGIT = 3'd1,
		PH_DAY    = 3'd2,
		PH_COLON  = 3'd3,
		PH_NDIGIT = 3'd4,
		PH_CHECK  = 3'd5,
		PH_AFTER  = 3'd6
	} phase_t;

	// Special character codes.
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_DASH    = 8'd45;
	localparam logic [7:0] CH_COLON   = 8'd58;
	localparam logic [7:0] CH_ZERO    = 8'd48;
	localparam logic [7:0] CH_NINE    = 8'd57;

	localparam int ACC_W = 16;

endpackage

### rtl/list_header_day_crc_parser_unit.sv
// List header day/check parser: top level with input register, scan logic
// and result register. Depends on lhdcp_pkg.
`timescale 1ns / 1ps

// An item that ends a line (newline or end of input) is taken into the input
// register, and its result is loaded into the result register when the stage
// advances, that is when the result register is empty or being read.
// Throughput: one item per cycle; the scan phase and the multiply-by-ten
// accumulate fit in the single stage between input and result register.
// A result that waits on the output holds the input register and stalls input.
// Reset: arst_n clears the valid flags, the scan phase and both accumulators
// at once; the scan starts waiting for a dash.
module list_header_day_crc_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	input  logic [0:0]  s_axis_tuser,  // [0] end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [15:0] day_number, [31:16] check_value
	output logic [1:0]  m_axis_tuser   // [0] ok, [1] has_check
);

	localparam int AW = lhdcp_pkg::ACC_W;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              eoi_s1;

	lhdcp_pkg::phase_t phase_q, phase_d;
	logic [AW-1:0]     day_acc_q, day_acc_d;
	logic [AW-1:0]     check_acc_q, check_acc_d;

	logic              m_valid_q;
	logic [31:0]       m_data_q;
	logic [1:0]        m_user_q;

	logic              out_free;
	logic              advance;
	logic              is_digit;
	logic [AW-1:0]     digit;
	logic              emit;
	logic              res_ok;
	logic              res_check;

	// Handshake: the stage moves when the result register can take an item.
	assign out_free      = !m_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			eoi_s1  <= s_axis_tuser[0];
		end
	end

	// Character class of the registered byte.
	assign is_digit = (byte_s1 >= lhdcp_pkg::CH_ZERO) && (byte_s1 <= lhdcp_pkg::CH_NINE);
	assign digit    = {{(AW-8){1'b0}}, byte_s1 - lhdcp_pkg::CH_ZERO};
	assign emit     = eoi_s1 || (byte_s1 == lhdcp_pkg::CH_NEWLINE);

	// Next scan phase.
	always_comb begin
		phase_d = phase_q;
		if (emit) begin
			phase_d = lhdcp_pkg::PH_DASH;
		end else if (is_digit) begin
			if (phase_q == lhdcp_pkg::PH_FDIGIT) begin
				phase_d = lhdcp_pkg::PH_DAY;
			end else if (phase_q == lhdcp_pkg::PH_NDIGIT) begin
				phase_d = lhdcp_pkg::PH_CHECK;
			end
		end else if (byte_s1 == lhdcp_pkg::CH_DASH) begin
			if (phase_q == lhdcp_pkg::PH_DASH) begin
				phase_d = lhdcp_pkg::PH_FDIGIT;
			end
		end else if (byte_s1 == lhdcp_pkg::CH_COLON) begin
			if (phase_q == lhdcp_pkg::PH_COLON) begin
				phase_d = lhdcp_pkg::PH_NDIGIT;
			end
		end else begin
			if (phase_q == lhdcp_pkg::PH_CHECK) begin
				phase_d = lhdcp_pkg::PH_AFTER;
			end else if (phase_q == lhdcp_pkg::PH_DAY) begin
				phase_d = lhdcp_pkg::PH_COLON;
			end
		end
	end

	// Accumulators and result flags.
	always_comb begin
		day_acc_d   = day_acc_q;
		check_acc_d = check_acc_q;
		res_ok      = 1'b0;
		res_check   = 1'b0;
		if (emit) begin
			day_acc_d   = '0;
			check_acc_d = '0;
			if (!eoi_s1) begin
				res_ok    = (phase_q >= lhdcp_pkg::PH_DAY);
				res_check = (phase_q >= lhdcp_pkg::PH_CHECK);
			end
		end else if (is_digit) begin
			unique case (phase_q)
				lhdcp_pkg::PH_FDIGIT: day_acc_d   = digit;
				lhdcp_pkg::PH_NDIGIT: check_acc_d = digit;
				lhdcp_pkg::PH_DAY:
					day_acc_d = (day_acc_q << 3) + (day_acc_q << 1) + digit;
				lhdcp_pkg::PH_CHECK:
					check_acc_d = (check_acc_q << 3) + (check_acc_q << 1) + digit;
				default: ;
			endcase
		end
	end

	// Scan state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= lhdcp_pkg::PH_DASH;
			day_acc_q   <= '0;
			check_acc_q <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			day_acc_q   <= day_acc_d;
			check_acc_q <= check_acc_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			m_data_q <= {check_acc_q, day_acc_q};
			m_user_q <= {res_check, res_ok};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

### rtl/lhdcp_checker.sv
// Port-level checks for the list header day/check parser, with the bind
// that attaches them to list_header_day_crc_parser_unit.
`timescale 1ns / 1ps

module lhdcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// A check value is only seen after the day field was reached.
	a_check_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[0] || !m_axis_tuser[1]))
		else $error("has_check set without ok");

	// With the result register empty the input side always takes an item.
	a_ready_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while no result waits");

	// A stalled result stays offered.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
			($stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("result payload changed while stalled");

endmodule

bind list_header_day_crc_parser_unit lhdcp_checker u_lhdcp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### test/tb_list_header_day_crc_parser_unit.sv
// Testbench for the list header day/check parser unit.
// Drives header bytes over the input stream, predicts each line result and
// checks the output stream against it. Depends on lhdcp_pkg and the top level.
`timescale 1ns / 1ps

module tb_list_header_day_crc_parser_unit;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 4;
	localparam int ITEMS_PER_RUN = 225;
	localparam int TAIL_CYCLES   = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam logic [15:0] RADIX = 16'd10;

	// One header byte as queued for the driver.
	typedef struct {
		logic [7:0] ch;
		logic       eoi;
		logic       drain;  // hold this item back until all line results are in
	} header_item_t;

	// One line result as the block reports it.
	typedef struct {
		logic        ok;
		logic        has_check;
		logic [15:0] day;
		logic [15:0] check;
	} line_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] in_byte
	logic [0:0]  s_axis_tuser = 1'b0;   // [0] end_of_input
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;          // [15:0] day_number, [31:16] check_value
	logic [1:0]  m_axis_tuser;          // [0] ok, [1] has_check

	header_item_t pending_bytes[$];
	line_result_t line_results[$];
	int           pushed = 0;
	int           errors = 0;
	int           cycles = 0;
	int           sender_idle_pct = 0;
	int           sink_stall_pct = 0;

	// Predicted scan state.
	lhdcp_pkg::phase_t model_phase = lhdcp_pkg::PH_DASH;
	logic [15:0]       model_day = 16'd0;
	logic [15:0]       model_check = 16'd0;

	list_header_day_crc_parser_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Advance the predicted scan by one accepted item and queue any line result.
	task automatic scan_header_byte(input logic [7:0] ch, input logic eoi);
		line_result_t res;
		logic [15:0]  digit;
		digit = {8'd0, ch - lhdcp_pkg::CH_ZERO};
		if (eoi || ch == lhdcp_pkg::CH_NEWLINE) begin
			res.ok        = !eoi && (model_phase >= lhdcp_pkg::PH_DAY);
			res.has_check = !eoi && (model_phase >= lhdcp_pkg::PH_CHECK);
			res.day       = model_day;
			res.check     = model_check;
			line_results.push_back(res);
			model_phase = lhdcp_pkg::PH_DASH;
			model_day   = 16'd0;
			model_check = 16'd0;
		end else if (ch >= lhdcp_pkg::CH_ZERO && ch <= lhdcp_pkg::CH_NINE) begin
			case (model_phase)
				lhdcp_pkg::PH_FDIGIT: begin
					model_day   = digit;
					model_phase = lhdcp_pkg::PH_DAY;
				end
				lhdcp_pkg::PH_NDIGIT: begin
					model_check = digit;
					model_phase = lhdcp_pkg::PH_CHECK;
				end
				lhdcp_pkg::PH_DAY:   model_day = model_day * RADIX + digit;
				lhdcp_pkg::PH_CHECK: model_check = model_check * RADIX + digit;
				default: ;
			endcase
		end else if (ch == lhdcp_pkg::CH_DASH) begin
			if (model_phase == lhdcp_pkg::PH_DASH)
				model_phase = lhdcp_pkg::PH_FDIGIT;
		end else if (ch == lhdcp_pkg::CH_COLON) begin
			if (model_phase == lhdcp_pkg::PH_COLON)
				model_phase = lhdcp_pkg::PH_NDIGIT;
		end else begin
			// Any other character closes an open digit run.
			if (model_phase == lhdcp_pkg::PH_CHECK)
				model_phase = lhdcp_pkg::PH_AFTER;
			else if (model_phase == lhdcp_pkg::PH_DAY)
				model_phase = lhdcp_pkg::PH_COLON;
		end
	endtask

	task automatic push_byte(input logic [7:0] ch, input logic eoi, input logic drain);
		header_item_t it;
		it.ch    = ch;
		it.eoi   = eoi;
		it.drain = drain;
		pending_bytes.push_back(it);
		pushed++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], 1'b0, 1'b0);
	endtask

	// A byte that none of the scan phases treats specially.
	function automatic logic [7:0] other_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(255));
		end while ((c >= lhdcp_pkg::CH_ZERO && c <= lhdcp_pkg::CH_NINE) ||
			c == lhdcp_pkg::CH_DASH || c == lhdcp_pkg::CH_COLON ||
			c == lhdcp_pkg::CH_NEWLINE);
		return c;
	endfunction

	// Mostly well-formed header lines with random content, some cut short,
	// some pure noise, ended by a newline or by end of input.
	task automatic queue_random_line(input logic drain);
		logic [7:0] text[$];
		int         cut;
		if ($urandom_range(99) < 80) begin
			repeat ($urandom_range(0, 2)) text.push_back(other_char());
			text.push_back(lhdcp_pkg::CH_DASH);
			repeat ($urandom_range(1, 6))
				text.push_back(lhdcp_pkg::CH_ZERO + 8'($urandom_range(9)));
			repeat ($urandom_range(1, 2)) text.push_back(other_char());
			text.push_back(lhdcp_pkg::CH_COLON);
			repeat ($urandom_range(1, 6))
				text.push_back(lhdcp_pkg::CH_ZERO + 8'($urandom_range(9)));
			repeat ($urandom_range(0, 2)) text.push_back(other_char());
			repeat ($urandom_range(0, 1))
				text.push_back(lhdcp_pkg::CH_ZERO + 8'($urandom_range(9)));
		end else begin
			repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(255)));
		end
		if ($urandom_range(99) < 25) begin
			cut = $urandom_range(text.size());
			while (text.size() > cut)
				void'(text.pop_back());
		end
		foreach (text[i])
			push_byte(text[i], 1'b0, drain && (i == 0));
		if ($urandom_range(99) < 12)
			push_byte(8'($urandom_range(255)), 1'b1, drain && (text.size() == 0));
		else
			push_byte(lhdcp_pkg::CH_NEWLINE, 1'b0, drain && (text.size() == 0));
	endtask

	// Driver: present the oldest pending item, idling at random between items.
	always @(posedge clk) begin : drive_input
		logic fire;
		logic go;
		if (arst_n) begin
			fire = s_axis_tvalid && s_axis_tready;
			if (fire) begin
				scan_header_byte(s_axis_tdata, s_axis_tuser[0]);
				void'(pending_bytes.pop_front());
			end
			if (!s_axis_tvalid || fire) begin
				go = pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct;
				if (go && pending_bytes[0].drain && line_results.size() != 0)
					go = 1'b0;
				s_axis_tvalid <= go;
				if (go) begin
					s_axis_tdata    <= pending_bytes[0].ch;
					s_axis_tuser[0] <= pending_bytes[0].eoi;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest prediction.
	always @(posedge clk) begin : check_output
		line_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (line_results.size() == 0) begin
					$display("%0t: unexpected result tuser=%b tdata=%h", $time,
						m_axis_tuser, m_axis_tdata);
					errors++;
				end else begin
					want = line_results.pop_front();
					if (m_axis_tuser[0] !== want.ok) begin
						$display("%0t: ok expected %b actual %b", $time, want.ok,
							m_axis_tuser[0]);
						errors++;
					end
					if (m_axis_tuser[1] !== want.has_check) begin
						$display("%0t: has_check expected %b actual %b", $time,
							want.has_check, m_axis_tuser[1]);
						errors++;
					end
					if (m_axis_tdata[15:0] !== want.day) begin
						$display("%0t: day_number expected %0d actual %0d", $time,
							want.day, m_axis_tdata[15:0]);
						errors++;
					end
					if (m_axis_tdata[31:16] !== want.check) begin
						$display("%0t: check_value expected %0d actual %0d", $time,
							want.check, m_axis_tdata[31:16]);
						errors++;
					end
				end
			end
			m_axis_tready <= $urandom_range(99) >= sink_stall_pct;
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Stimulus: directed lines, then random lines over several idling phases.
	initial begin : stimulus
		int target;
		int lines;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Newline while still waiting for the dash.
		push_text("\n");
		// Newline right after the dash; a high byte is ignored there.
		push_text("-");
		push_byte(8'hFF, 1'b0, 1'b0);
		push_text("\n");
		// Stray colon, day that wraps, ignored dash, digit and colon, check
		// value starting with zero, ignored digit after the check value.
		push_text(":-99999-");
		push_byte(8'h80, 1'b0, 1'b0);
		push_text("5::07");
		push_byte(8'hFF, 1'b0, 1'b0);
		push_text("3\n");
		// End of input in the middle of a line; its byte is a newline to be ignored.
		push_text("-1");
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(lhdcp_pkg::CH_NEWLINE, 1'b1, 1'b0);

		for (int p = 0; p < 4; p++) begin
			@(negedge clk);
			case (p)
				0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin sender_idle_pct = 84; sink_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  sink_stall_pct = 84; end
				default: begin sender_idle_pct = 7; sink_stall_pct = 7; end
			endcase
			target = pushed + ITEMS_PER_RUN;
			lines = 0;
			while (pushed < target) begin
				queue_random_line((p == 1 || p == 2) && (lines % 8 == 7));
				lines++;
			end
			while (pending_bytes.size() != 0) @(posedge clk);
		end

		while (line_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
rtl/lhdcp_pkg.sv
rtl/list_header_day_crc_parser_unit.sv
rtl/lhdcp_checker.sv
test/tb_list_header_day_crc_parser_unit.sv
